// File: hw/rtl/scanline_color_run_plotter_core_defines.svh
// Assertion macros shared by the checker of the scanline color run plotter.
`ifndef SCANLINE_COLOR_RUN_PLOTTER_CORE_DEFINES_SVH
`define SCANLINE_COLOR_RUN_PLOTTER_CORE_DEFINES_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define SCRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrp check failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrp check failed");

`endif

// File: hw/rtl/scrp_pkg.sv
// Types, constants and helper functions of the scanline color run plotter.
package scrp_pkg;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int COLOR_W = 6;
    localparam int ROWS_W  = 56;
    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_LAYERS  = 7;
    localparam int LAYER_W     = 3;

    typedef enum logic [1:0] {
        KIND_DEF_START = 2'd0,
        KIND_LAYER     = 2'd1,
        KIND_SELECT    = 2'd2,
        KIND_VECTOR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_BEGIN,
        ST_START,
        ST_LAYER,
        ST_SELECT,
        ST_VECTOR
    } back_state_t;

    // One request from the front: up to two runs to close, in order.
    typedef struct packed {
        logic               has_a;
        logic [COLOR_W-1:0] color_a;
        logic [COL_W-1:0]   xs_a;
        logic               has_b;
        logic [COLOR_W-1:0] color_b;
        logic [COL_W-1:0]   xs_b;
        logic [COL_W-1:0]   xe;
        logic [ROW_W-1:0]   row;
    } run_req_t;

    localparam logic [2:0] BG_CODE = 3'd7;

    localparam logic [7:0] RED_MASK [4] = '{8'h00, 8'h88, 8'hca, 8'hff};
    localparam logic [7:0] GRN_MASK [4] = '{8'h00, 8'h44, 8'hb2, 8'hff};
    localparam logic [7:0] BLU_MASK [4] = '{8'h00, 8'h22, 8'h2d, 8'hff};
    localparam logic [2:0] LAYER_CODE [NUM_LAYERS] =
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd5, 3'd0};

    function automatic logic [1:0] level(input logic [15:0] v);
        logic [1:0] res;
        if (v >= 16'd4096) res = 2'd3;
        else res = v[11:10];
        return res;
    endfunction

    function automatic logic [7:0] layer_mask(input logic [COLOR_W-1:0] color,
                                              input logic [LAYER_W-1:0] idx);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] m;
        r = RED_MASK[color[5:4]];
        g = GRN_MASK[color[3:2]];
        b = BLU_MASK[color[1:0]];
        case (idx)
            3'd0:    m = r & ~(g | b);
            3'd1:    m = g & ~(r | b);
            3'd2:    m = b & ~(r | g);
            3'd3:    m = r & g & ~b;
            3'd4:    m = r & b & ~g;
            3'd5:    m = g & b & ~r;
            3'd6:    m = r & g & b;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] rotr(input logic [7:0] p, input int k);
        logic [15:0] d;
        d = {p, p} >> (k % 8);
        return d[7:0];
    endfunction

    // Seven rows of a layer half; each is the previous one rotated right by 3.
    function automatic logic [ROWS_W-1:0] pattern_half(input logic [7:0] p,
                                                       input logic half,
                                                       input int pattern_rows);
        logic [ROWS_W-1:0] res;
        int idx;
        res = '0;
        for (int i = 0; i < 7; i++) begin
            idx = half ? i + 7 : i;
            if (idx < pattern_rows) begin
                res[8*i +: 8] = half ? rotr(p, 3 * (i + 7)) : rotr(p, 3 * i);
            end
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/scanline_color_run_plotter_core.sv
// Top level of the scanline color run plotter.
// Pixels are pushed one per cycle while full is low; the front quantizes each pixel to a
// 6-bit color, tracks the open run and places a request into a two-entry queue only when a
// run closes, so a pixel that continues a run produces no result. The back takes requests
// from that queue and places at most one result per cycle into the output register, while
// that register is empty or being popped: a closed run gives a select and a vector result,
// and the first use of a color adds a start result, one or two halves for each non-empty
// layer and a step without a result for each empty layer. The back's sequencer sets the
// sustained throughput; full rises when the request queue holds two requests.
module scanline_color_run_plotter_core
#(
    parameter int MAX_COLUMNS  = 1024,
    parameter int MAX_ROWS     = 512,
    parameter int PATTERN_ROWS = 14
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic [8:0]  row,
    input  logic        last_in_line,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [5:0]  color,
    output logic [2:0]  layer_code,
    output logic        half,
    output logic [55:0] rows_packed,
    output logic [9:0]  x_start,
    output logic [9:0]  x_end,
    output logic [8:0]  out_row,
    output logic        last
);

    logic               accept;
    logic               req_valid;
    scrp_pkg::run_req_t req;
    scrp_pkg::run_req_t head;
    logic               head_valid;
    logic               head_pop;

    assign accept = push && !full;

    scrp_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .row          (row),
        .last_in_line (last_in_line),
        .accept       (accept),
        .req_valid    (req_valid),
        .req          (req)
    );

    scrp_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (req_valid),
        .wr_data   (req),
        .full      (full),
        .rd_en     (head_pop),
        .rd_data   (head),
        .not_empty (head_valid)
    );

    scrp_back #(
        .PATTERN_ROWS (PATTERN_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .color       (color),
        .layer_code  (layer_code),
        .half        (half),
        .rows_packed (rows_packed),
        .x_start     (x_start),
        .x_end       (x_end),
        .out_row     (out_row),
        .last        (last)
    );

endmodule

// File: hw/rtl/scrp_fifo.sv
// Short request queue between the front and the back of the plotter.
module scrp_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  scrp_pkg::run_req_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output scrp_pkg::run_req_t rd_data,
    output logic               not_empty
);

    localparam int PTR_W = (scrp_pkg::QUEUE_DEPTH > 1) ? $clog2(scrp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(scrp_pkg::QUEUE_DEPTH + 1);

    scrp_pkg::run_req_t mem [scrp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full      = (count_reg == CNT_W'(scrp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(scrp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(scrp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/scrp_front.sv
// Front of the plotter: quantizes pixels, tracks runs and issues run requests.
module scrp_front
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         red,
    input  logic [15:0]         green,
    input  logic [15:0]         blue,
    input  logic [8:0]          row,
    input  logic                last_in_line,
    input  logic                accept,
    output logic                req_valid,
    output scrp_pkg::run_req_t  req
);

    logic [scrp_pkg::COL_W-1:0]   column_reg;
    logic [scrp_pkg::COL_W-1:0]   column_next;
    logic [scrp_pkg::COLOR_W-1:0] run_color_reg;
    logic [scrp_pkg::COLOR_W-1:0] run_color_next;
    logic [scrp_pkg::COL_W-1:0]   run_start_reg;
    logic [scrp_pkg::COL_W-1:0]   run_start_next;
    logic                         run_open_reg;
    logic                         run_open_next;
    logic [scrp_pkg::COLOR_W-1:0] color;
    logic [scrp_pkg::ROW_W-1:0]   row_sat;
    logic                         line_end;
    logic                         change;

    always_comb
    begin
        color    = {scrp_pkg::level(red), scrp_pkg::level(green), scrp_pkg::level(blue)};
        row_sat  = (32'(row) > MAX_ROWS - 1) ? scrp_pkg::ROW_W'(MAX_ROWS - 1) : row;
        line_end = last_in_line || (32'(column_reg) >= MAX_COLUMNS - 1);
        change   = run_open_reg && (color != run_color_reg);

        // A run that stays open keeps its color and start; otherwise this pixel opens one.
        if (run_open_reg && !change)
        begin
            run_color_next = run_color_reg;
            run_start_next = run_start_reg;
        end
        else
        begin
            run_color_next = color;
            run_start_next = column_reg;
        end
        run_open_next = !line_end;
        column_next   = line_end ? '0 : column_reg + 1'b1;

        req.has_a   = change;
        req.color_a = run_color_reg;
        req.xs_a    = run_start_reg;
        req.has_b   = line_end;
        req.color_b = run_color_next;
        req.xs_b    = run_start_next;
        req.xe      = column_reg;
        req.row     = row_sat;
        req_valid   = accept && (change || line_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            run_color_reg <= '0;
            run_start_reg <= '0;
            run_open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            column_reg    <= column_next;
            run_color_reg <= run_color_next;
            run_start_reg <= run_start_next;
            run_open_reg  <= run_open_next;
        end
    end

endmodule

// File: hw/rtl/scrp_back.sv
// Back of the plotter: expands run requests into start, pattern, select and vector results.
module scrp_back
#(
    parameter int PATTERN_ROWS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  scrp_pkg::run_req_t  head,
    input  logic                head_valid,
    output logic                head_pop,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          kind,
    output logic [5:0]          color,
    output logic [2:0]          layer_code,
    output logic                half,
    output logic [55:0]         rows_packed,
    output logic [9:0]          x_start,
    output logic [9:0]          x_end,
    output logic [8:0]          out_row,
    output logic                last
);

    scrp_pkg::back_state_t        state_reg;
    scrp_pkg::back_state_t        state_next;
    scrp_pkg::back_state_t        work;
    logic                         op_sel_reg;
    logic                         op_sel_next;
    logic [scrp_pkg::LAYER_W-1:0] layer_reg;
    logic [scrp_pkg::LAYER_W-1:0] layer_next;
    logic                         half_reg;
    logic                         half_next;
    logic [63:0]                  defined_reg;
    logic [63:0]                  defined_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    scrp_pkg::kind_t              kind_reg;
    scrp_pkg::kind_t              kind_next;
    logic [5:0]                   color_reg;
    logic [5:0]                   color_next;
    logic [2:0]                   code_reg;
    logic [2:0]                   code_next;
    logic                         half_out_reg;
    logic                         half_out_next;
    logic [55:0]                  rows_reg;
    logic [55:0]                  rows_next;
    logic [9:0]                   xs_reg;
    logic [9:0]                   xs_next;
    logic [9:0]                   xe_reg;
    logic [9:0]                   xe_next;
    logic [8:0]                   row_reg;
    logic [8:0]                   row_next;
    logic                         last_reg;
    logic                         last_next;

    logic                         cur_op;
    logic [5:0]                   cur_color;
    logic [9:0]                   cur_xs;
    logic [7:0]                   mask;
    logic                         can_emit;
    logic                         emit;

    assign empty       = !out_valid_reg;
    assign kind        = kind_reg;
    assign color       = color_reg;
    assign layer_code  = code_reg;
    assign half        = half_out_reg;
    assign rows_packed = rows_reg;
    assign x_start     = xs_reg;
    assign x_end       = xe_reg;
    assign out_row     = row_reg;
    assign last        = last_reg;

    always_comb
    begin
        // At the start of a request without a changed run, go straight to the end-of-line run.
        cur_op    = op_sel_reg || ((state_reg == scrp_pkg::ST_BEGIN) && !head.has_a);
        cur_color = cur_op ? head.color_b : head.color_a;
        cur_xs    = cur_op ? head.xs_b : head.xs_a;
        mask      = scrp_pkg::layer_mask(cur_color, layer_reg);
        can_emit  = !out_valid_reg || pop;

        work = state_reg;
        if (state_reg == scrp_pkg::ST_BEGIN)
        begin
            work = defined_reg[cur_color] ? scrp_pkg::ST_SELECT : scrp_pkg::ST_START;
        end

        state_next    = state_reg;
        op_sel_next   = op_sel_reg;
        layer_next    = layer_reg;
        half_next     = half_reg;
        defined_next  = defined_reg;
        head_pop      = 1'b0;
        emit          = 1'b0;
        kind_next     = kind_reg;
        color_next    = color_reg;
        code_next     = code_reg;
        half_out_next = half_out_reg;
        rows_next     = rows_reg;
        xs_next       = xs_reg;
        xe_next       = xe_reg;
        row_next      = row_reg;
        last_next     = last_reg;

        if (head_valid && can_emit)
        begin
            color_next    = cur_color;
            code_next     = '0;
            half_out_next = 1'b0;
            rows_next     = '0;
            xs_next       = '0;
            xe_next       = '0;
            row_next      = '0;
            last_next     = 1'b0;
            op_sel_next   = cur_op;
            unique case (work)
                scrp_pkg::ST_START:
                begin
                    emit         = 1'b1;
                    kind_next    = scrp_pkg::KIND_DEF_START;
                    code_next    = scrp_pkg::BG_CODE;
                    defined_next = defined_reg | (64'd1 << cur_color);
                    layer_next   = '0;
                    half_next    = 1'b0;
                    state_next   = scrp_pkg::ST_LAYER;
                end
                scrp_pkg::ST_LAYER:
                begin
                    // Layers with an empty mask are skipped without a result.
                    emit          = (mask != 8'h00);
                    kind_next     = scrp_pkg::KIND_LAYER;
                    code_next     = scrp_pkg::LAYER_CODE[layer_reg];
                    half_out_next = half_reg;
                    rows_next     = scrp_pkg::pattern_half(mask, half_reg, PATTERN_ROWS);
                    if ((mask != 8'h00) && !half_reg && (PATTERN_ROWS > 7))
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (layer_reg == scrp_pkg::LAYER_W'(scrp_pkg::NUM_LAYERS - 1))
                        begin
                            state_next = scrp_pkg::ST_SELECT;
                        end
                        else
                        begin
                            layer_next = layer_reg + 1'b1;
                        end
                    end
                end
                scrp_pkg::ST_SELECT:
                begin
                    emit       = 1'b1;
                    kind_next  = scrp_pkg::KIND_SELECT;
                    state_next = scrp_pkg::ST_VECTOR;
                end
                scrp_pkg::ST_VECTOR:
                begin
                    emit       = 1'b1;
                    kind_next  = scrp_pkg::KIND_VECTOR;
                    xs_next    = cur_xs;
                    xe_next    = head.xe;
                    row_next   = head.row;
                    state_next = scrp_pkg::ST_BEGIN;
                    if (!cur_op && head.has_b)
                    begin
                        op_sel_next = 1'b1;
                    end
                    else
                    begin
                        last_next   = 1'b1;
                        op_sel_next = 1'b0;
                        head_pop    = 1'b1;
                    end
                end
                default:
                begin
                    state_next = scrp_pkg::ST_BEGIN;
                end
            endcase
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scrp_pkg::ST_BEGIN;
            op_sel_reg    <= 1'b0;
            layer_reg     <= '0;
            half_reg      <= 1'b0;
            defined_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_sel_reg    <= op_sel_next;
            layer_reg     <= layer_next;
            half_reg      <= half_next;
            defined_reg   <= defined_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg     <= kind_next;
            color_reg    <= color_next;
            code_reg     <= code_next;
            half_out_reg <= half_out_next;
            rows_reg     <= rows_next;
            xs_reg       <= xs_next;
            xe_reg       <= xe_next;
            row_reg      <= row_next;
            last_reg     <= last_next;
        end
    end

endmodule

// File: hw/rtl/scrp_checker.sv
// Port-level checker of the scanline color run plotter and its bind statement.
`include "scanline_color_run_plotter_core_defines.svh"

module scrp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  kind,
    input logic [5:0]  color,
    input logic [2:0]  layer_code,
    input logic        half,
    input logic [55:0] rows_packed,
    input logic [9:0]  x_start,
    input logic [9:0]  x_end,
    input logic [8:0]  out_row,
    input logic        last
);

    logic out_held;
    logic sel_taken;
    logic vec_shown;
    logic layer_shown;

    assign out_held    = !empty && !pop;
    assign sel_taken   = !empty && pop && (kind == scrp_pkg::KIND_SELECT);
    assign vec_shown   = !empty && (kind == scrp_pkg::KIND_VECTOR);
    assign layer_shown = !empty && (kind == scrp_pkg::KIND_LAYER);

    // A waiting result that is not taken stays as it is.
    `SCRP_ASSERT_NEXT(a_hold, out_held, !empty && $stable(kind) && $stable(color) && $stable(last))

    // A popped color select is followed at once by the vector of the same color.
    `SCRP_ASSERT_NEXT(a_sel_then_vec, sel_taken, vec_shown && color == $past(color))

    // Only a vector closes the results of a request.
    `SCRP_ASSERT_SAME(a_last_on_vec, !empty && last, vec_shown)

    // A run never starts after the column where it ends.
    `SCRP_ASSERT_SAME(a_run_order, vec_shown, x_start <= x_end)

    // Pattern layers carry a real layer code and a nonzero row set.
    `SCRP_ASSERT_SAME(a_layer_ok, layer_shown, layer_code != scrp_pkg::BG_CODE && rows_packed != '0)

endmodule

bind scanline_color_run_plotter_core scrp_checker u_scrp_checker (.*);
